// ----- src/int8q_pkg.sv -----
package int8q_pkg;

  localparam int THR_W   = 16;
  localparam int FLOOR_W = 15;
  localparam int ACT_W   = 16;
  localparam int CODE_W  = 8;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 1;

  localparam logic [IDX_W-1:0] CFG_OUTLIER_THRESHOLD = 1'd0;
  localparam logic [IDX_W-1:0] CFG_ABSMAX_FLOOR      = 1'd1;

  localparam logic [THR_W-1:0]   THR_RESET   = 16'd1536;
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = 15'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// ----- src/int8_absmax_weight_quantizer.sv -----
// INT8 absmax weight quantizer, one output channel with outlier columns.
// Stream the channel row twice over the input channel (in_valid/in_stall):
// first with mode 0 (measure), then with mode 1 (quantize); row_last marks
// the final element of each pass. Only the last measure element gives a
// result: a report (result_kind 1) with the floored channel absmax in
// value_out. Every quantize element gives one result: outlier columns pass
// the weight through with outlier_flag set, regular columns give a rounded,
// clipped int8_code.
// One item is in flight at a time. A measure element that is not last is
// absorbed at its transfer; the next item can follow in the next cycle.
// Reports and outlier results pass through ST_OUT into the output register.
// Regular quantize elements go through ST_MUL, ST_DIV and ST_OUT: multiply
// by CODE_MAX, one restoring-division step per quotient bit, rounding into
// the output register; the input reopens as the result enters it.
// The output register holds a result while out_stall is high; the next item
// is still taken and finishes into its work registers, then waits for the
// output register to free up. Registers are written over cfg_write /
// cfg_index / cfg_data while the block is idle; the user is bound to this,
// the block itself does not enforce it. rst (synchronous) clears the running
// max, sets the channel absmax to one and the registers to defaults.
module int8_absmax_weight_quantizer #(
  parameter int WEIGHT_BITS = 16,
  parameter int CODE_MAX    = 127
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [int8q_pkg::IDX_W-1:0]         cfg_index,
  input  logic [int8q_pkg::CFG_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                mode,
  input  logic signed [WEIGHT_BITS-1:0]       weight_value,
  input  logic [int8q_pkg::ACT_W-1:0]         column_act_absmax,
  input  logic                                row_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                result_kind,
  output logic signed [int8q_pkg::CODE_W-1:0] int8_code,
  output logic                                outlier_flag,
  output logic signed [WEIGHT_BITS-1:0]       value_out
);

  localparam int WB    = WEIGHT_BITS;
  localparam int QB    = $clog2(CODE_MAX + 1);
  localparam int NW    = WB - 1 + QB;
  localparam int CA_W  = (WB - 1 > int8q_pkg::FLOOR_W) ? WB - 1 : int8q_pkg::FLOOR_W;
  localparam int CNT_W = $clog2(QB);
  localparam int CW    = int8q_pkg::CODE_W;

  int8q_pkg::state_t state, state_next;

  logic [int8q_pkg::THR_W-1:0]   thr;
  logic [int8q_pkg::FLOOR_W-1:0] floor_reg;
  logic [WB-2:0]                 running;
  logic [CA_W-1:0]               chan;

  logic          job_div, job_kind, job_flag, job_neg;
  logic [WB-1:0] job_value;
  logic [WB-1:0] abs_w;

  logic [CA_W:0]      part;
  logic [QB-1:0]      nlow;
  logic [QB-1:0]      quo;
  logic               sat;
  logic [CNT_W-1:0]   cnt;

  logic acc, out_free, out_load;

  // accept-side arithmetic
  logic                        outl;
  logic [WB-1:0]               mag_full;
  logic [WB-2:0]               a_sat;
  logic [WB-2:0]               run_new;
  logic [int8q_pkg::FLOOR_W-1:0] fl_eff;
  logic [CA_W-1:0]             ch_new;

  always_comb begin
    outl     = column_act_absmax > thr;
    mag_full = weight_value[WB-1] ? (~weight_value + WB'(1)) : weight_value;
    a_sat    = mag_full[WB-1] ? '1 : mag_full[WB-2:0];
    run_new  = (!outl && a_sat > running) ? a_sat : running;
    fl_eff   = (floor_reg == '0) ? int8q_pkg::FLOOR_W'(1) : floor_reg;
    ch_new   = (CA_W'(run_new) > CA_W'(fl_eff)) ? CA_W'(run_new) : CA_W'(fl_eff);
  end

  // multiply and divide step
  logic [WB+QB-1:0] prod;
  logic [NW-1:0]    n;
  logic [WB-2:0]    n_hi;
  logic             n_sat;
  logic [CA_W:0]    trial;
  logic             qbit;

  always_comb begin
    prod  = (WB+QB)'(abs_w) * (WB+QB)'(CODE_MAX);
    n     = prod[NW-1:0];
    n_hi  = n[NW-1:QB];
    n_sat = CA_W'(n_hi) >= chan;
    trial = {part[CA_W-1:0], nlow[QB-1]};
    qbit  = trial >= {1'b0, chan};
  end

  // rounding
  logic [CA_W:0]   twice_r;
  logic            round_up;
  logic [QB:0]     qr;
  logic [CW-1:0]   mag8;
  logic [CW-1:0]   code_next;

  always_comb begin
    twice_r  = {part[CA_W-1:0], 1'b0};
    round_up = (twice_r > {1'b0, chan}) || (twice_r == {1'b0, chan} && quo[0]);
    qr       = {1'b0, quo} + (QB+1)'(round_up);
    if (sat || qr > (QB+1)'(CODE_MAX)) begin
      mag8 = CW'(CODE_MAX);
    end else begin
      mag8 = CW'(qr);
    end
    if (!job_div) begin
      code_next = '0;
    end else if (job_neg) begin
      code_next = -mag8;
    end else begin
      code_next = mag8;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      int8q_pkg::ST_IDLE: begin
        if (acc) begin
          priority if (mode && !outl) state_next = int8q_pkg::ST_MUL;
          else if (!mode && !row_last) state_next = int8q_pkg::ST_IDLE;
          else state_next = int8q_pkg::ST_OUT;
        end
      end
      int8q_pkg::ST_MUL: state_next = int8q_pkg::ST_DIV;
      int8q_pkg::ST_DIV: begin
        if (cnt == CNT_W'(QB - 1)) state_next = int8q_pkg::ST_OUT;
      end
      int8q_pkg::ST_OUT: begin
        if (out_free) state_next = int8q_pkg::ST_IDLE;
      end
      default: state_next = int8q_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != int8q_pkg::ST_IDLE);
    acc      = in_valid && !in_stall;
    out_free = !out_valid || !out_stall;
    out_load = (state == int8q_pkg::ST_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= int8q_pkg::ST_IDLE;
      thr       <= int8q_pkg::THR_RESET;
      floor_reg <= int8q_pkg::FLOOR_RESET;
      running   <= '0;
      chan      <= CA_W'(1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          int8q_pkg::CFG_OUTLIER_THRESHOLD: thr       <= cfg_data;
          int8q_pkg::CFG_ABSMAX_FLOOR:      floor_reg <= cfg_data[int8q_pkg::FLOOR_W-1:0];
          default: ;
        endcase
      end
      if (acc && !mode) begin
        if (row_last) begin
          chan    <= ch_new;
          running <= '0;
        end else begin
          running <= run_new;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      job_kind  <= !mode;
      job_flag  <= mode && outl;
      job_div   <= mode && !outl;
      job_neg   <= weight_value[WB-1];
      abs_w     <= mag_full;
      job_value <= !mode ? WB'(ch_new) : (outl ? weight_value : '0);
    end
    unique case (state)
      int8q_pkg::ST_MUL: begin
        sat  <= n_sat;
        part <= n_sat ? '0 : (CA_W+1)'(n_hi);
        nlow <= n[QB-1:0];
        quo  <= '0;
        cnt  <= '0;
      end
      int8q_pkg::ST_DIV: begin
        part <= qbit ? (trial - {1'b0, chan}) : trial;
        nlow <= {nlow[QB-2:0], 1'b0};
        quo  <= {quo[QB-2:0], qbit};
        cnt  <= cnt + CNT_W'(1);
      end
      default: ;
    endcase
    if (out_load) begin
      result_kind  <= job_kind;
      outlier_flag <= job_flag;
      value_out    <= job_value;
      int8_code    <= code_next;
    end
  end

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    state == int8q_pkg::ST_DIV |-> part < {1'b0, chan})
    else $error("division remainder not below divisor");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    acc && mode |=> state != int8q_pkg::ST_IDLE)
    else $error("quantize element accepted but block went idle");

  a_report_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind |-> int8_code == '0 && !outlier_flag)
    else $error("report carries code or outlier flag");

  a_outlier_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && outlier_flag |-> int8_code == '0 && !result_kind)
    else $error("outlier result carries a code");

  a_chan_nonzero: assert property (@(posedge clk) disable iff (rst)
    chan != '0)
    else $error("channel absmax is zero");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam logic MODE_MEASURE  = 1'b0;
  localparam logic MODE_QUANTIZE = 1'b1;
  localparam logic KIND_ELEMENT  = 1'b0;
  localparam logic KIND_REPORT   = 1'b1;
  localparam int   CODE_LIMIT    = 127;
  localparam int   MAG_LIMIT     = 32767;
  localparam int   HOLD_CYCLES   = 300;
  localparam int   SETTLE_CYCLES = 20;
  localparam int   QUIET_LIMIT   = 4000;
  localparam int   MAX_ROW       = 32;
  localparam int   MAX_REPORTS   = 10;

  typedef struct {
    logic                                kind;
    logic signed [int8q_pkg::CODE_W-1:0] code;
    logic                                flag;
    logic signed [15:0]                  value;
  } quant_result_t;

  class quant_scoreboard;
    logic [int8q_pkg::THR_W-1:0]   thr_reg;
    logic [int8q_pkg::FLOOR_W-1:0] floor_reg;
    int                            running_max;
    int                            channel_max;
    quant_result_t                 expected_results[$];
    int                            mismatches;

    function new();
      thr_reg     = int8q_pkg::THR_RESET;
      floor_reg   = int8q_pkg::FLOOR_RESET;
      running_max = 0;
      channel_max = 1;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [int8q_pkg::IDX_W-1:0] idx,
                            logic [int8q_pkg::CFG_W-1:0] data);
      case (idx)
        int8q_pkg::CFG_OUTLIER_THRESHOLD: thr_reg = data[int8q_pkg::THR_W-1:0];
        int8q_pkg::CFG_ABSMAX_FLOOR:      floor_reg = data[int8q_pkg::FLOOR_W-1:0];
        default: ;
      endcase
    endfunction

    // round half to even of w * 127 / d, clipped
    function int code_of(int w, int d);
      int num, n, q, rem;
      num = w * CODE_LIMIT;
      n   = num < 0 ? -num : num;
      q   = n / d;
      rem = n % d;
      if (2 * rem > d || (2 * rem == d && q % 2 == 1)) q++;
      if (q > CODE_LIMIT) q = CODE_LIMIT;
      return num < 0 ? -q : q;
    endfunction

    function void note_transfer(logic m, logic signed [15:0] w,
                                logic [int8q_pkg::ACT_W-1:0] act, logic last);
      quant_result_t r;
      int            wi, mag, fl;
      logic          outl;
      wi      = w;
      outl    = act > thr_reg;
      r.kind  = KIND_ELEMENT;
      r.code  = '0;
      r.flag  = 1'b0;
      r.value = '0;
      if (m == MODE_MEASURE) begin
        if (!outl) begin
          mag = wi < 0 ? -wi : wi;
          if (mag > MAG_LIMIT) mag = MAG_LIMIT;
          if (mag > running_max) running_max = mag;
        end
        if (!last) return;
        fl          = (floor_reg == 0) ? 1 : int'(floor_reg);
        channel_max = running_max > fl ? running_max : fl;
        running_max = 0;
        r.kind      = KIND_REPORT;
        r.value     = channel_max[15:0];
      end else if (outl) begin
        r.flag  = 1'b1;
        r.value = w;
      end else begin
        r.code = code_of(wi, channel_max);
      end
      expected_results.insert(expected_results.size(), r);
    endfunction

    function void check_result(quant_result_t got);
      quant_result_t e;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: kind %0d code %0d flag %0d value %0d",
                   got.kind, got.code, got.flag, got.value);
        return;
      end
      e = expected_results.pop_front();
      if (got.kind !== e.kind || got.code !== e.code || got.flag !== e.flag ||
          got.value !== e.value) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: kind %0d/%0d code %0d/%0d flag %0d/%0d value %0d/%0d (exp/got)",
                   e.kind, got.kind, e.code, got.code, e.flag, got.flag, e.value, got.value);
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                cfg_write;
  logic [int8q_pkg::IDX_W-1:0]         cfg_index;
  logic [int8q_pkg::CFG_W-1:0]         cfg_data;
  logic                                in_valid;
  logic                                in_stall;
  logic                                mode;
  logic signed [15:0]                  weight_value;
  logic [int8q_pkg::ACT_W-1:0]         column_act_absmax;
  logic                                row_last;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic                                result_kind;
  logic signed [int8q_pkg::CODE_W-1:0] int8_code;
  logic                                outlier_flag;
  logic signed [15:0]                  value_out;

  quant_scoreboard sb;
  int              send_idle_pct = 0;
  int              stall_pct = 0;
  bit              hold_req = 0;
  int              hold_left = 0;
  int              quiet_cycles = 0;
  int              xfer_count = 0;
  logic [15:0]     cur_thr = int8q_pkg::THR_RESET;

  int8_absmax_weight_quantizer u_top (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .mode              (mode),
    .weight_value      (weight_value),
    .column_act_absmax (column_act_absmax),
    .row_last          (row_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .result_kind       (result_kind),
    .int8_code         (int8_code),
    .outlier_flag      (outlier_flag),
    .value_out         (value_out)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    quant_result_t got;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got.kind  = result_kind;
        got.code  = int8_code;
        got.flag  = outlier_flag;
        got.value = value_out;
        sb.check_result(got);
      end
      if (in_valid && !in_stall)
        sb.note_transfer(mode, weight_value, column_act_absmax, row_last);
      if (cfg_write)
        sb.write_reg(cfg_index, cfg_data);
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || cfg_write)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("tb: errors");
    $finish;
  end

  task automatic send_element(logic m, logic [15:0] w, logic [15:0] act, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    mode              <= m;
    weight_value      <= w;
    column_act_absmax <= act;
    row_last          <= last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    xfer_count++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_regs(logic [15:0] thr, logic [15:0] fl);
    cfg_write <= 1'b1;
    cfg_index <= int8q_pkg::CFG_OUTLIER_THRESHOLD;
    cfg_data  <= thr;
    @(negedge clk);
    cfg_index <= int8q_pkg::CFG_ABSMAX_FLOOR;
    cfg_data  <= fl;
    @(negedge clk);
    cfg_write <= 1'b0;
    cur_thr = thr;
  endtask

  function automatic logic [15:0] pick_weight();
    int v;
    v = $urandom_range(512);
    v = v - 256;
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return v[15:0];
      3: return $urandom_range(1) ? 16'h0001 : 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_act();
    case ($urandom_range(9))
      0: return cur_thr;
      1: return cur_thr + 16'd1;
      2: return 16'h0000;
      3: return 16'hffff;
      4, 5, 6: return 16'($urandom_range(cur_thr));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_row(int len, bit altered);
    logic [15:0] wts[MAX_ROW];
    logic [15:0] acts[MAX_ROW];
    logic [15:0] wq;
    for (int i = 0; i < len; i++) begin
      wts[i]  = pick_weight();
      acts[i] = pick_act();
    end
    for (int i = 0; i < len; i++)
      send_element(MODE_MEASURE, wts[i], acts[i], i == len - 1);
    for (int i = 0; i < len; i++) begin
      wq = (altered && $urandom_range(1)) ? pick_weight() : wts[i];
      send_element(MODE_QUANTIZE, wq, acts[i], i == len - 1);
    end
  endtask

  task automatic run_directed();
    // saturating magnitude, threshold equality, outlier, report on last
    send_element(MODE_MEASURE, 16'sd32767, 16'd0, 1'b0);
    send_element(MODE_MEASURE, -16'sd32768, 16'd1536, 1'b0);
    send_element(MODE_MEASURE, 16'sd100, 16'd1537, 1'b0);
    send_element(MODE_MEASURE, 16'sd0, 16'hffff, 1'b1);
    send_element(MODE_QUANTIZE, -16'sd32768, 16'd0, 1'b0);
    send_element(MODE_QUANTIZE, 16'sd32767, 16'd0, 1'b0);
    send_element(MODE_QUANTIZE, 16'sd16384, 16'd0, 1'b0);
    send_element(MODE_QUANTIZE, 16'sd1000, 16'hffff, 1'b0);
    send_element(MODE_QUANTIZE, 16'sd0, 16'd0, 1'b1);
    // all outliers: floor wins, then oversized weights saturate
    send_element(MODE_MEASURE, 16'sd5000, 16'd2000, 1'b1);
    send_element(MODE_QUANTIZE, -16'sd1, 16'd0, 1'b0);
    send_element(MODE_QUANTIZE, 16'sd32767, 16'd0, 1'b1);
    // ties at half
    send_element(MODE_MEASURE, 16'sd2, 16'd0, 1'b1);
    send_element(MODE_QUANTIZE, 16'sd1, 16'd0, 1'b0);
    send_element(MODE_QUANTIZE, 16'sd3, 16'd0, 1'b1);
    send_element(MODE_MEASURE, 16'sd254, 16'd0, 1'b0);
    send_element(MODE_MEASURE, -16'sd100, 16'd100, 1'b1);
    send_element(MODE_QUANTIZE, 16'sd1, 16'd0, 1'b0);
    send_element(MODE_QUANTIZE, 16'sd3, 16'd0, 1'b0);
    send_element(MODE_QUANTIZE, 16'sd5, 16'd0, 1'b0);
    send_element(MODE_QUANTIZE, -16'sd3, 16'd0, 1'b0);
    send_element(MODE_QUANTIZE, -16'sd32768, 16'd0, 1'b1);
  endtask

  initial begin
    int          target;
    int          len;
    bit          paused;
    logic [15:0] thr_val;
    logic [15:0] floor_val;
    sb                = new();
    rst               = 1'b1;
    cfg_write         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_valid          = 1'b0;
    mode              = MODE_MEASURE;
    weight_value      = '0;
    column_act_absmax = '0;
    row_last          = 1'b0;
    paused            = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_directed();

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      case (p)
        0: begin thr_val = 16'hffff; floor_val = 16'd32767; end
        1: begin thr_val = 16'h0000; floor_val = 16'h0000; end
        2: begin thr_val = 16'($urandom); floor_val = 16'h8000; end
        3: begin thr_val = int8q_pkg::THR_RESET; floor_val = 16'd1; end
        4: begin thr_val = 16'd256; floor_val = 16'($urandom_range(32767, 1)); end
        5: begin thr_val = 16'($urandom); floor_val = 16'd200; end
        6: begin thr_val = 16'hffff; floor_val = 16'd1; end
        default: begin thr_val = 16'($urandom); floor_val = 16'($urandom); end
      endcase
      set_regs(thr_val, floor_val);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 64; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 64; end
        default: begin send_idle_pct = 13; stall_pct = 13; end
      endcase
      if (p == 0) hold_req = 1;
      target = xfer_count + 240;
      while (xfer_count < target) begin
        if (p == 4 && !paused && xfer_count > target - 120) begin
          paused = 1;
          wait_idle();
        end
        if ($urandom_range(99) < 8) begin
          send_element(1'($urandom_range(1)), 16'($urandom), 16'($urandom),
                       1'($urandom_range(1)));
        end else begin
          len = ($urandom_range(99) < 85) ? $urandom_range(8, 1) : $urandom_range(MAX_ROW, 9);
          run_row(len, $urandom_range(99) < 10);
        end
      end
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/int8q_pkg.sv
src/int8_absmax_weight_quantizer.sv
tb/tb.sv
